// File: sv/resp_request_deframer_defines.svh
// assertion macros for the request deframer
// expects signals clk and arst_n in the scope of use; no other dependencies
`ifndef RESP_REQUEST_DEFRAMER_DEFINES_SVH
`define RESP_REQUEST_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrd check failed");

// next-cycle implication, checked outside reset
`define RRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrd check failed");

`endif

// File: sv/rrd_pkg.sv
// types and constants for the request deframer
// no dependencies
package rrd_pkg;

	localparam int COUNT_BITS = 31;
	localparam logic [31:0] MAX_COUNT = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [31:0] BAD_NUM = 32'hFFFF_FFFF;
	localparam logic [31:0] NUM_LIMIT = 32'h8000_0000;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] SKIP_BYTES = 2'd2;

	// parser phases
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_WS = 4'd1;
	localparam logic [3:0] PH_COUNT = 4'd2;
	localparam logic [3:0] PH_DOLLAR = 4'd3;
	localparam logic [3:0] PH_LEN = 4'd4;
	localparam logic [3:0] PH_PAYLOAD = 4'd5;
	localparam logic [3:0] PH_SKIP = 4'd6;
	localparam logic [3:0] PH_DONE_OK = 4'd7;
	localparam logic [3:0] PH_DONE_BAD = 4'd8;
	localparam logic [3:0] PH_DONE_HDR = 4'd9;

	// number scanner stages
	localparam logic [1:0] NS_LEAD = 2'd0;
	localparam logic [1:0] NS_SIGN = 2'd1;
	localparam logic [1:0] NS_DIGITS = 2'd2;
	localparam logic [1:0] NS_TAIL = 2'd3;

	// parse status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_ELEM = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_BAD_HDR = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        token_open;
		logic        token_close;
		logic [30:0] token_total;
		logic        finished;
		logic [1:0]  parse_status;
	} tok_t;

	typedef struct packed {
		logic [1:0]  stage;
		logic [31:0] value;
		logic        neg;
	} num_t;

endpackage

// File: sv/resp_request_deframer.sv
// request deframer top level: splits a request byte stream into tokens
// depends on rrd_pkg and resp_request_deframer_defines.svh
//
//  channel   direction  payload  handshake
//  req       in         req_t    req_valid / req_stall
//  tok       out        tok_t    tok_valid / tok_stall
//
// one byte per clock while req_stall is low: each transfer is parsed in the cycle
// it is taken and its result is registered in the output register
// the parse state update is a single pass, bounded by the length-line
// multiply-by-ten and add
// req_stall rises only while a held result is stalled on the output side
// a byte that yields no result still updates the parse state
// arst_n clears the parser to the awaiting-first-byte state
`include "resp_request_deframer_defines.svh"

module resp_request_deframer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rrd_pkg::req_t req_data,
	output logic          tok_valid,
	input  logic          tok_stall,
	output rrd_pkg::tok_t tok_data
);
	import rrd_pkg::*;

	// one step of the decimal scanner
	function automatic num_t num_feed(input num_t s, input logic [7:0] c);
		num_t        n;
		logic        digit;
		logic        space;
		logic [35:0] v;
		n = s;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		v = ({4'd0, s.value} << 3) + ({4'd0, s.value} << 1) + {28'd0, c - CH_ZERO};
		if (s.stage == NS_LEAD && space) begin
			n = s;
		end else if (s.stage == NS_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
			n.neg = (c == CH_MINUS);
			n.stage = NS_SIGN;
		end else if (s.stage == NS_LEAD || s.stage == NS_SIGN) begin
			if (digit) begin
				n.value = {24'd0, c - CH_ZERO};
				n.stage = NS_DIGITS;
			end else begin
				n.value = BAD_NUM;
				n.stage = NS_TAIL;
			end
		end else if (s.stage == NS_DIGITS) begin
			if (digit) begin
				n.value = (v > {4'd0, NUM_LIMIT}) ? BAD_NUM : v[31:0];
			end else begin
				n.stage = NS_TAIL;
			end
		end
		return n;
	endfunction

	logic [3:0]            phase_q;
	logic                  saw_cr_q;
	num_t                  num_q;
	logic [COUNT_BITS-1:0] elem_left_q;
	logic [COUNT_BITS-1:0] pay_left_q;
	logic [1:0]            skip_left_q;
	logic [COUNT_BITS-1:0] tok_cnt_q;
	logic                  in_word_q;
	logic                  tok_valid_q;
	tok_t                  tok_q;

	logic [3:0]            phase_n;
	logic                  saw_cr_n;
	num_t                  num_n;
	logic [COUNT_BITS-1:0] elem_left_n;
	logic [COUNT_BITS-1:0] pay_left_n;
	logic [1:0]            skip_left_n;
	logic [COUNT_BITS-1:0] tok_cnt_n;
	logic                  in_word_n;
	tok_t                  res;
	logic                  has_res;

	// number line scan, shared by the count and length lines
	num_t                  nb_num;
	logic                  nb_cr;
	logic                  nb_done;
	logic                  nb_ok;
	logic                  nb_big;

	logic                  accept;
	logic [7:0]            c;
	logic                  last;

	assign accept = req_valid && !req_stall;
	assign req_stall = tok_valid_q && tok_stall;
	assign c = req_data.in_byte;
	assign last = req_data.last_byte;

	always_comb begin
		nb_num = num_q;
		nb_cr = saw_cr_q;
		nb_done = 1'b0;
		if (saw_cr_q) begin
			if (c == CH_LF) begin
				nb_done = 1'b1;
			end else begin
				// lone cr is number text
				nb_num = num_feed(num_q, CH_CR);
				nb_cr = (c == CH_CR);
				if (c != CH_CR) begin
					nb_num = num_feed(nb_num, c);
				end
			end
		end else if (c == CH_CR) begin
			nb_cr = 1'b1;
		end else begin
			nb_num = num_feed(num_q, c);
		end
		// number is valid once it has digits and fits the signed 32-bit range
		nb_ok = (num_q.stage == NS_DIGITS || num_q.stage == NS_TAIL)
			&& (num_q.value != BAD_NUM)
			&& (num_q.value <= NUM_LIMIT)
			&& !(num_q.value == NUM_LIMIT && !num_q.neg);
		nb_big = num_q.value > MAX_COUNT;
	end

	// parse step
	always_comb begin
		logic [3:0] run_ph;
		logic       jump;
		logic       close;
		phase_n = phase_q;
		saw_cr_n = saw_cr_q;
		num_n = num_q;
		elem_left_n = elem_left_q;
		pay_left_n = pay_left_q;
		skip_left_n = skip_left_q;
		tok_cnt_n = tok_cnt_q;
		in_word_n = in_word_q;
		res = '0;
		run_ph = phase_q;
		jump = 1'b0;
		close = 1'b0;

		// first byte picks array mode or whitespace mode
		if (phase_q == PH_IDLE) begin
			tok_cnt_n = '0;
			in_word_n = 1'b0;
			if (c == CH_STAR) begin
				phase_n = PH_COUNT;
				saw_cr_n = 1'b0;
				num_n = '0;
				jump = 1'b1;
			end else begin
				phase_n = PH_WS;
				run_ph = PH_WS;
			end
		end

		if (!jump) begin
			case (run_ph)
				PH_WS: begin
					if (c inside {8'h20, [8'h09:8'h0D]}) begin
						close = in_word_n;
						in_word_n = 1'b0;
					end else begin
						res.token_open = !in_word_n;
						in_word_n = 1'b1;
						res.out_byte = c;
						res.byte_valid = 1'b1;
						if (last) begin
							close = 1'b1;
							in_word_n = 1'b0;
						end
					end
				end
				PH_COUNT: begin
					num_n = nb_num;
					saw_cr_n = nb_cr;
					if (nb_done) begin
						if (!nb_ok || (!num_q.neg && nb_big)) begin
							phase_n = PH_DONE_HDR;
						end else if (num_q.neg || num_q.value == '0) begin
							// empty array
							phase_n = PH_DONE_OK;
						end else begin
							elem_left_n = num_q.value[COUNT_BITS-1:0];
							phase_n = PH_DOLLAR;
						end
					end
				end
				PH_DOLLAR: begin
					if (c == CH_DOLLAR) begin
						saw_cr_n = 1'b0;
						num_n = '0;
						phase_n = PH_LEN;
					end else begin
						phase_n = PH_DONE_BAD;
					end
				end
				PH_LEN: begin
					num_n = nb_num;
					saw_cr_n = nb_cr;
					if (nb_done) begin
						if (!nb_ok || num_q.neg || nb_big) begin
							phase_n = PH_DONE_BAD;
						end else begin
							res.token_open = 1'b1;
							pay_left_n = num_q.value[COUNT_BITS-1:0];
							skip_left_n = SKIP_BYTES;
							phase_n = (num_q.value != '0) ? PH_PAYLOAD : PH_SKIP;
						end
					end
				end
				PH_PAYLOAD: begin
					res.out_byte = c;
					res.byte_valid = 1'b1;
					pay_left_n = pay_left_q - 1'b1;
					if (pay_left_n == '0) begin
						phase_n = PH_SKIP;
					end
				end
				PH_SKIP: begin
					// trailing pair is not checked
					skip_left_n = skip_left_q - 2'd1;
					if (skip_left_n == 2'd0) begin
						close = 1'b1;
						elem_left_n = elem_left_q - 1'b1;
						phase_n = (elem_left_n != '0) ? PH_DOLLAR : PH_DONE_OK;
					end
				end
				default: begin
				end
			endcase

			// saturating token count
			if (close && ({{(32-COUNT_BITS){1'b0}}, tok_cnt_n} < MAX_COUNT)) begin
				tok_cnt_n = tok_cnt_n + 1'b1;
			end
		end

		// end of request: report status and rearm
		if (last) begin
			case (phase_n)
				PH_DONE_BAD: res.parse_status = ST_BAD_ELEM;
				PH_DONE_HDR: res.parse_status = ST_BAD_HDR;
				PH_WS,
				PH_DONE_OK: res.parse_status = ST_OK;
				default: res.parse_status = ST_TRUNC;
			endcase
			phase_n = PH_IDLE;
			saw_cr_n = 1'b0;
			num_n = '0;
			elem_left_n = '0;
			pay_left_n = '0;
			skip_left_n = '0;
			in_word_n = 1'b0;
		end

		res.token_close = close;
		res.token_total = 31'(tok_cnt_n);
		res.finished = last;
		has_res = res.byte_valid || res.token_open || close || last;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			saw_cr_q <= 1'b0;
			num_q <= '0;
			elem_left_q <= '0;
			pay_left_q <= '0;
			skip_left_q <= '0;
			tok_cnt_q <= '0;
			in_word_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			saw_cr_q <= saw_cr_n;
			num_q <= num_n;
			elem_left_q <= elem_left_n;
			pay_left_q <= pay_left_n;
			skip_left_q <= skip_left_n;
			tok_cnt_q <= tok_cnt_n;
			in_word_q <= in_word_n;
		end
	end

	// output register: takes a new result whenever the old one is gone or leaving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (accept) begin
			tok_valid_q <= has_res;
		end else if (!tok_stall) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			tok_q <= res;
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_data = tok_q;

	// a confirmed token always leaves a nonzero count
	`RRD_ASSERT_NOW(a_close_counts, tok_valid_q && tok_q.token_close, tok_q.token_total != '0)
	// status is only reported with the end of a request
	`RRD_ASSERT_NOW(a_status_end, tok_valid_q && !tok_q.finished, tok_q.parse_status == ST_OK)
	// a request end always rearms the parser
	`RRD_ASSERT_NEXT(a_end_rearm, accept && last, phase_q == PH_IDLE)
	// a byte-free result carries a cleared byte
	`RRD_ASSERT_NOW(a_byte_clear, tok_valid_q && !tok_q.byte_valid, tok_q.out_byte == 8'd0)

endmodule
